// ===== src/ohlcv_pkg.sv =====
// ----------------------------------------------------------------------------
// ohlcv_pkg
// Shared types and constants of the OHLCV time-bucket resampler.
// ----------------------------------------------------------------------------
package ohlcv_pkg;

  localparam int unsigned TS_W    = 40;
  localparam int unsigned PX_W    = 32;
  localparam int unsigned VOL_W   = 48;
  localparam int unsigned TOV_W   = 63;
  localparam int unsigned BAR_W   = TS_W + 4 * PX_W + VOL_W + TOV_W;
  localparam int unsigned TDATA_W = ((BAR_W + 7) / 8) * 8;

  localparam longint unsigned DAY_SECONDS    = 86400;
  localparam longint unsigned BUCKET_SECONDS = 1800;

  // 86400 = 2^7 * 675: shift first, then divide the odd part by reciprocal
  localparam int unsigned     DAY_SHIFT    = 7;
  localparam longint unsigned DAY_ODD      = DAY_SECONDS >> DAY_SHIFT;
  localparam int unsigned     DAY_X_W      = TS_W - DAY_SHIFT;
  localparam int unsigned     DAY_RECIP_SH = DAY_X_W;
  localparam longint unsigned DAY_RECIP    = (64'd1 << DAY_RECIP_SH) / DAY_ODD;
  localparam int unsigned     DAY_RECIP_W  = $clog2(DAY_RECIP + 1);
  localparam int unsigned     DAY_P_W      = DAY_X_W + DAY_RECIP_W;
  localparam int unsigned     DAY_W        = $clog2(((64'd1 << TS_W) - 1) / DAY_SECONDS + 1);
  localparam int unsigned     ODD_W        = $clog2(DAY_ODD);
  localparam int unsigned     DAY_REM_W    = ODD_W + 1;
  localparam int unsigned     OFF_W        = ODD_W + DAY_SHIFT;

  localparam int unsigned     SLOT_SH      = 34;
  localparam longint unsigned SLOT_RECIP   = (64'd1 << SLOT_SH) / BUCKET_SECONDS;
  localparam int unsigned     SLOT_RECIP_W = $clog2(SLOT_RECIP + 1);
  localparam int unsigned     SLOT_P_W     = OFF_W + SLOT_RECIP_W;
  localparam int unsigned     SLOT_W       = $clog2(DAY_SECONDS / BUCKET_SECONDS + 1);

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  // last field (timestamp) in the lowest bits
  typedef struct packed {
    logic [TOV_W-1:0] turnover;
    logic [VOL_W-1:0] volume;
    logic [PX_W-1:0]  close_price;
    logic [PX_W-1:0]  low_price;
    logic [PX_W-1:0]  high_price;
    logic [PX_W-1:0]  open_price;
    logic [TS_W-1:0]  timestamp;
  } bar_t;

  typedef struct packed {
    bar_t bar;
    logic last_bar;
  } item_t;

  typedef struct packed {
    logic run_end;
    bar_t bar;
  } res_t;

  typedef struct packed {
    logic v0;
    logic v1;
    res_t d0;
    res_t d1;
  } push_t;

endpackage

// ===== src/ohlcv_key_pipe.sv =====
// ----------------------------------------------------------------------------
// ohlcv_key_pipe
// Pipelined bucket key: day by reciprocal, slot by reciprocal, rebuild start.
// ----------------------------------------------------------------------------
module ohlcv_key_pipe (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  ohlcv_pkg::item_t        item_i,
  output logic                    valid_o,
  output ohlcv_pkg::item_t        item_o,
  output logic [ohlcv_pkg::TS_W-1:0] key_o
);
  import ohlcv_pkg::*;

  logic             v0_q, v1_q, v2_q, v3_q, v4_q;
  item_t            it0_q, it1_q, it2_q, it3_q, it4_q;
  logic [DAY_P_W-1:0]  pday_q;
  logic [DAY_W-1:0]    day_q;
  logic [OFF_W-1:0]    off2_q, off3_q;
  logic [SLOT_P_W-1:0] pslot_q;
  logic [TS_W-1:0]     dbase_q;
  logic [TS_W-1:0]     key_q;

  logic [DAY_P_W-1:0]  pday_d;
  logic [DAY_X_W-1:0]  x1;
  logic [DAY_W-1:0]    est_day;
  logic [DAY_X_W-1:0]  prod_day;
  logic [DAY_X_W-1:0]  rem_full;
  logic [DAY_REM_W-1:0] rem_day;
  logic                day_fix;
  logic [DAY_REM_W-1:0] rem_fixed;
  logic [DAY_W-1:0]    day_d;
  logic [OFF_W-1:0]    off_d;
  logic [SLOT_W-1:0]   est_slot;
  logic [OFF_W-1:0]    sbase;
  logic [OFF_W-1:0]    srem;
  logic [OFF_W-1:0]    sbase_fixed;
  logic [TS_W-1:0]     key_d;

  // stage 1: day estimate product
  always_comb begin
    pday_d = DAY_P_W'(it0_q.bar.timestamp[TS_W-1:DAY_SHIFT]) * DAY_P_W'(DAY_RECIP);
  end

  // stage 2: day correction and offset in day
  always_comb begin
    x1        = it1_q.bar.timestamp[TS_W-1:DAY_SHIFT];
    est_day   = pday_q[DAY_RECIP_SH +: DAY_W];
    prod_day  = DAY_X_W'(est_day) * DAY_X_W'(DAY_ODD);
    rem_full  = x1 - prod_day;
    rem_day   = rem_full[DAY_REM_W-1:0];
    day_fix   = rem_day >= DAY_REM_W'(DAY_ODD);
    rem_fixed = day_fix ? rem_day - DAY_REM_W'(DAY_ODD) : rem_day;
    day_d     = est_day + DAY_W'(day_fix);
    off_d     = {rem_fixed[ODD_W-1:0], it1_q.bar.timestamp[DAY_SHIFT-1:0]};
  end

  // stage 4: slot correction and bucket start
  always_comb begin
    est_slot    = pslot_q[SLOT_SH +: SLOT_W];
    sbase       = OFF_W'(est_slot) * OFF_W'(BUCKET_SECONDS);
    srem        = off3_q - sbase;
    sbase_fixed = (srem >= OFF_W'(BUCKET_SECONDS)) ? sbase + OFF_W'(BUCKET_SECONDS) : sbase;
    key_d       = dbase_q + TS_W'(sbase_fixed);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it0_q   <= item_i;
      it1_q   <= it0_q;
      pday_q  <= pday_d;
      it2_q   <= it1_q;
      day_q   <= day_d;
      off2_q  <= off_d;
      it3_q   <= it2_q;
      off3_q  <= off2_q;
      pslot_q <= SLOT_P_W'(off2_q) * SLOT_P_W'(SLOT_RECIP);
      dbase_q <= TS_W'(day_q) * TS_W'(DAY_SECONDS);
      it4_q   <= it3_q;
      key_q   <= key_d;
    end
  end

  assign valid_o = v4_q;
  assign item_o  = it4_q;
  assign key_o   = key_q;

endmodule

// ===== src/ohlcv_bar_agg.sv =====
// ----------------------------------------------------------------------------
// ohlcv_bar_agg
// Running bar: merge within a bucket, emit on key change and on last bar.
// ----------------------------------------------------------------------------
module ohlcv_bar_agg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  ohlcv_pkg::item_t           item_i,
  input  logic [ohlcv_pkg::TS_W-1:0] key_i,
  output ohlcv_pkg::push_t           push_o
);
  import ohlcv_pkg::*;

  logic have_q, have_d;
  bar_t agg_q, agg_d;
  logic match;
  logic take;
  logic emit_old;
  logic flush;
  logic [VOL_W:0] vol_sum;
  logic [TOV_W:0] tov_sum;

  always_comb begin
    take    = valid_i && en_i;
    match   = have_q && (key_i == agg_q.timestamp);
    vol_sum = {1'b0, agg_q.volume} + {1'b0, item_i.bar.volume};
    tov_sum = {1'b0, agg_q.turnover} + {1'b0, item_i.bar.turnover};

    if (match) begin
      agg_d            = agg_q;
      agg_d.high_price = (item_i.bar.high_price > agg_q.high_price) ?
                         item_i.bar.high_price : agg_q.high_price;
      agg_d.low_price  = (item_i.bar.low_price < agg_q.low_price) ?
                         item_i.bar.low_price : agg_q.low_price;
      agg_d.close_price = item_i.bar.close_price;
      agg_d.volume     = vol_sum[VOL_W] ? '1 : vol_sum[VOL_W-1:0];
      agg_d.turnover   = tov_sum[TOV_W] ? '1 : tov_sum[TOV_W-1:0];
    end else begin
      agg_d           = item_i.bar;
      agg_d.timestamp = key_i;
    end

    have_d   = take ? !item_i.last_bar : have_q;
    emit_old = take && have_q && !match;
    flush    = take && item_i.last_bar;

    push_o.d1 = '{run_end: 1'b1, bar: agg_d};
    if (emit_old) begin
      push_o.v0 = 1'b1;
      push_o.d0 = '{run_end: !item_i.last_bar, bar: agg_q};
      push_o.v1 = flush;
    end else begin
      push_o.v0 = flush;
      push_o.d0 = '{run_end: 1'b1, bar: agg_d};
      push_o.v1 = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      agg_q <= agg_d;
    end
  end

endmodule

// ===== src/ohlcv_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ohlcv_out_fifo
// Small result queue: up to two writes, one read per cycle.
// ----------------------------------------------------------------------------
module ohlcv_out_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ohlcv_pkg::push_t push_i,
  output logic             room_o,
  output logic             valid_o,
  input  logic             ready_i,
  output ohlcv_pkg::res_t  data_o
);
  import ohlcv_pkg::*;

  res_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_q, wr_d;
  logic [FIFO_PTR_W-1:0] rd_q, rd_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic [FIFO_PTR_W-1:0] wr_next;
  logic [1:0]            n_push;
  logic                  pop;

  always_comb begin
    n_push  = {1'b0, push_i.v0} + {1'b0, push_i.v1};
    pop     = valid_o && ready_i;
    wr_next = wr_q + FIFO_PTR_W'(1);
    wr_d    = wr_q + FIFO_PTR_W'(n_push);
    rd_d    = rd_q + FIFO_PTR_W'(pop);
    cnt_d   = cnt_q + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0) begin
      mem_q[wr_q] <= push_i.d0;
    end
    if (push_i.v1) begin
      mem_q[wr_next] <= push_i.d1;
    end
  end

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign room_o  = cnt_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);

endmodule

// ===== src/ohlcv_time_bucket_resampler.sv =====
// ----------------------------------------------------------------------------
// ohlcv_time_bucket_resampler
// Merges a time-ordered bar stream into day-aligned fixed-length buckets.
// ----------------------------------------------------------------------------
//  channel   dir  tdata (low bit up)                                tlast
//  s_axis    in   timestamp, open, high, low, close, volume, turnover  last_bar
//  m_axis    out  bucket_start, open, high, low, close, volume, turnover run_end
//
//  One item accepted per cycle while the result queue has room.
//  The key pipeline (5 stages, two reciprocal multiplies) and the running-bar
//  stage advance together; they hold while the 4-entry result queue has fewer
//  than two free entries. An item causes up to two results, so a run of
//  flushing items is paced by the result side. Reset clears valids, the
//  running-bar flag and the queue.
// ----------------------------------------------------------------------------
module ohlcv_time_bucket_resampler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // timestamp, open_price, high_price, low_price, close_price, volume, turnover
  input  logic [ohlcv_pkg::TDATA_W-1:0]    s_axis_tdata,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // bucket_start, out_open, out_high, out_low, out_close, out_volume, out_turnover
  output logic [ohlcv_pkg::TDATA_W-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast
);
  import ohlcv_pkg::*;

  logic            en;
  item_t           in_item;
  logic            key_valid;
  item_t           key_item;
  logic [TS_W-1:0] key;
  push_t           push;
  res_t            res;

  assign in_item.bar      = bar_t'(s_axis_tdata[BAR_W-1:0]);
  assign in_item.last_bar = s_axis_tlast;
  assign s_axis_tready    = en;

  ohlcv_key_pipe u_key (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .item_i  (in_item),
    .valid_o (key_valid),
    .item_o  (key_item),
    .key_o   (key)
  );

  ohlcv_bar_agg u_agg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (key_valid),
    .item_i  (key_item),
    .key_i   (key),
    .push_o  (push)
  );

  ohlcv_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (en),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res)
  );

  assign m_axis_tdata = TDATA_W'(res.bar);
  assign m_axis_tlast = res.run_end;

endmodule
